/* src/clipped_line_rasterizer_defines.svh */
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_defines
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_LINE_RASTERIZER_DEFINES_SVH
`define CLIPPED_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, off while in reset
`define CLR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define CLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// implication that is also checked during reset
`define CLR_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/clr_pkg.sv */
// ----------------------------------------------------------------------------
// clr_pkg
// Widths, codes and shared types of the clipped line rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIM_MAX    = 16384;
	localparam int DIM_BITS   = $clog2(DIM_MAX) + 1;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int ERR_BITS   = COORD_BITS + 3;
	localparam int COLOR_BITS = 32;
	localparam int INDEX_BITS = 28;

	localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
	localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 2 * COORD_BITS + INDEX_BITS + COLOR_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam int CMP_BITS = COORD_BITS + DIM_BITS;
	localparam int MUL_BITS = (COORD_BITS + DIM_BITS > INDEX_BITS) ?
		(COORD_BITS + DIM_BITS) : INDEX_BITS;

	localparam int CFG_IDX_BITS = 2;

	// power of two, pointers wrap naturally
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = QPTR_BITS + 1;

	localparam logic [DIM_BITS-1:0] WIDTH_RST  = DIM_BITS'(1024);
	localparam logic [DIM_BITS-1:0] HEIGHT_RST = DIM_BITS'(768);
	localparam logic [DIM_BITS-1:0] PITCH_RST  = DIM_BITS'(1024);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_PITCH   = 2'd2,
		REG_SURFACE = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] width;
		logic [DIM_BITS-1:0] height;
		logic [DIM_BITS-1:0] pitch;
		logic                surface;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [COORD_BITS-1:0]  x0;
		logic [COORD_BITS-1:0]  y0;
		logic [COORD_BITS-1:0]  x1;
		logic [COORD_BITS-1:0]  y1;
		logic [DELTA_BITS-1:0]  dx;
		logic [DELTA_BITS-1:0]  ndy;
		logic                   sxn;
		logic                   syn;
		logic [ERR_BITS-1:0]    err;
		logic [COLOR_BITS-1:0]  color;
	} cmd_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  vis;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} pix_t;

endpackage

`default_nettype wire

/* src/clr_front.sv */
// ----------------------------------------------------------------------------
// clr_front
// Input side: decodes a beat into a command and does the line setup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clr_front (
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [clr_pkg::IN_DATA_BITS-1:0]  s_tdata,
	input  wire logic                              s_tuser,
	input  wire logic                              q_full,
	output logic                                   q_push,
	output clr_pkg::cmd_t                          q_cmd
);

	localparam int C = clr_pkg::COORD_BITS;
	localparam int D = clr_pkg::DELTA_BITS;
	localparam int E = clr_pkg::ERR_BITS;

	logic [C-1:0] x0, y0, x1, y1;
	logic [D-1:0] dxs, dys, dx, ady, ndy;

	assign x0 = s_tdata[0*C +: C];
	assign y0 = s_tdata[1*C +: C];
	assign x1 = s_tdata[2*C +: C];
	assign y1 = s_tdata[3*C +: C];

	assign dxs = {x1[C-1], x1} - {x0[C-1], x0};
	assign dys = {y1[C-1], y1} - {y0[C-1], y0};
	assign dx  = dxs[D-1] ? (D'(0) - dxs) : dxs;
	assign ady = dys[D-1] ? (D'(0) - dys) : dys;
	assign ndy = D'(0) - ady;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_cmd.kind  = clr_pkg::cmd_kind_t'(s_tuser);
		q_cmd.x0    = x0;
		q_cmd.y0    = y0;
		q_cmd.x1    = x1;
		q_cmd.y1    = y1;
		q_cmd.dx    = dx;
		q_cmd.ndy   = ndy;
		q_cmd.sxn   = !($signed(x0) < $signed(x1));
		q_cmd.syn   = !($signed(y0) < $signed(y1));
		q_cmd.err   = {{(E-D){1'b0}}, dx} + {{(E-D){ndy[D-1]}}, ndy};
		q_cmd.color = s_tdata[4*C +: clr_pkg::COLOR_BITS];
	end

endmodule

`default_nettype wire

/* src/clr_queue.sv */
// ----------------------------------------------------------------------------
// clr_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clr_queue (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire clr_pkg::cmd_t wr_cmd,
	output logic         full,
	output logic         head_valid,
	output clr_pkg::cmd_t head_cmd,
	input  wire logic    pop
);

	localparam int PB = clr_pkg::QPTR_BITS;
	localparam int CB = clr_pkg::QCNT_BITS;

	clr_pkg::cmd_t mem_q [clr_pkg::QUEUE_DEPTH];
	logic [PB-1:0] wr_ptr_q, rd_ptr_q;
	logic [CB-1:0] count_q;

	assign full       = (count_q == CB'(clr_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != CB'(0));
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PB'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PB'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + CB'(1);
				2'b01: count_q <= count_q - CB'(1);
				2'b00: count_q <= count_q;
				2'b11: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/clr_back.sv */
// ----------------------------------------------------------------------------
// clr_back
// Bresenham stepper: runs commands from the queue, one pixel per active step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clr_back (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire clr_pkg::cfg_t cfg,
	input  wire logic     head_valid,
	input  wire clr_pkg::cmd_t head_cmd,
	output logic          pop,
	input  wire logic     px_ready,
	output logic          px_valid_s1,
	output clr_pkg::pix_t px_s1
);

	localparam int C = clr_pkg::COORD_BITS;
	localparam int D = clr_pkg::DELTA_BITS;
	localparam int E = clr_pkg::ERR_BITS;
	localparam int M = clr_pkg::CMP_BITS;

	logic [C-1:0]                  cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic [D-1:0]                  dx_q, ndy_q;
	logic                          sxn_q, syn_q;
	logic [E-1:0]                  err_q;
	logic [clr_pkg::COLOR_BITS-1:0] color_q;
	logic                          active_q;

	logic         adv, emit, fin, vis, step_x, step_y;
	logic [E:0]   e2, ndy_ext, dx_ext;
	logic [E-1:0] err_next;

	assign adv  = !px_valid_s1 || px_ready;
	assign pop  = head_valid && adv;
	assign emit = pop && (head_cmd.kind == clr_pkg::CMD_STEP) && active_q;
	assign fin  = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);

	assign vis = cfg.surface && !cur_x_q[C-1] && !cur_y_q[C-1] &&
		({{(M-C){1'b0}}, cur_x_q} < {{(M-clr_pkg::DIM_BITS){1'b0}}, cfg.width}) &&
		({{(M-C){1'b0}}, cur_y_q} < {{(M-clr_pkg::DIM_BITS){1'b0}}, cfg.height});

	assign e2      = {err_q, 1'b0};
	assign ndy_ext = {{(E+1-D){ndy_q[D-1]}}, ndy_q};
	assign dx_ext  = {{(E+1-D){1'b0}}, dx_q};
	assign step_x  = $signed(e2) >= $signed(ndy_ext);
	assign step_y  = $signed(e2) <= $signed(dx_ext);
	assign err_next = err_q + (step_x ? ndy_ext[E-1:0] : E'(0))
		+ (step_y ? dx_ext[E-1:0] : E'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			px_valid_s1 <= 1'b0;
		end else begin
			if (pop) begin
				if (head_cmd.kind == clr_pkg::CMD_LOAD) begin
					active_q <= 1'b1;
				end else if (active_q && fin) begin
					active_q <= 1'b0;
				end
			end
			if (adv) begin
				px_valid_s1 <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_cmd.kind == clr_pkg::CMD_LOAD) begin
			cur_x_q <= head_cmd.x0;
			cur_y_q <= head_cmd.y0;
			end_x_q <= head_cmd.x1;
			end_y_q <= head_cmd.y1;
			dx_q    <= head_cmd.dx;
			ndy_q   <= head_cmd.ndy;
			sxn_q   <= head_cmd.sxn;
			syn_q   <= head_cmd.syn;
			err_q   <= head_cmd.err;
			color_q <= head_cmd.color;
		end else if (emit && !fin) begin
			err_q <= err_next;
			if (step_x) begin
				cur_x_q <= sxn_q ? (cur_x_q - C'(1)) : (cur_x_q + C'(1));
			end
			if (step_y) begin
				cur_y_q <= syn_q ? (cur_y_q - C'(1)) : (cur_y_q + C'(1));
			end
		end
		if (adv) begin
			px_s1.x     <= cur_x_q;
			px_s1.y     <= cur_y_q;
			px_s1.vis   <= vis;
			px_s1.color <= color_q;
			px_s1.last  <= fin;
		end
	end

endmodule

`default_nettype wire

/* src/clr_out.sv */
// ----------------------------------------------------------------------------
// clr_out
// Linear index multiply and the output register of the pixel stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clr_out (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire clr_pkg::cfg_t                     cfg,
	input  wire logic                              px_valid_s1,
	input  wire clr_pkg::pix_t                     px_s1,
	output logic                                   px_ready,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [clr_pkg::OUT_DATA_BITS-1:0]      m_tdata,
	output logic                                   m_tuser,
	output logic                                   m_tlast
);

	localparam int C = clr_pkg::COORD_BITS;
	localparam int M = clr_pkg::MUL_BITS;
	localparam int I = clr_pkg::INDEX_BITS;

	logic [M-1:0]                       prod;
	logic [I-1:0]                       index;
	logic [clr_pkg::OUT_DATA_BITS-1:0]  data_d;

	assign px_ready = !m_tvalid || m_tready;

	assign prod = {{(M-C){1'b0}}, px_s1.y} * {{(M-clr_pkg::DIM_BITS){1'b0}}, cfg.pitch}
		+ {{(M-C){1'b0}}, px_s1.x};
	assign index = px_s1.vis ? prod[I-1:0] : I'(0);

	always_comb begin
		data_d = '0;
		data_d[clr_pkg::OUT_FIELD_BITS-1:0] = {px_s1.color, index, px_s1.y, px_s1.x};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (px_ready) begin
			m_tvalid <= px_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (px_ready && px_valid_s1) begin
			m_tdata <= data_d;
			m_tuser <= px_s1.vis;
			m_tlast <= px_s1.last;
		end
	end

endmodule

`default_nettype wire

/* src/clipped_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Bresenham line rasterizer with per-pixel screen clipping.
// ----------------------------------------------------------------------------
//   Input beats on s_*: tuser is the opcode (0 load a line, 1 step), tdata the
//   endpoints and color. A load sets up the line and yields no output beat;
//   each step while a line is active yields one pixel beat on m_*, a step
//   while idle yields nothing. The pixel at the end point carries tlast and
//   ends the line.
//   Config writes (cfg_we, cfg_index, cfg_wdata) take effect at once and must be
//   made only while the block is idle; the block itself does not enforce this.
//   Throughput: one beat per cycle on both sides while the receiver does not
//   stall, set by the Bresenham update in the stepper. A step beat passes
//   through the command queue, the stepper stage and the index multiply into
//   the output register.
//   A four-entry command queue decouples the input from the stepper; when the
//   receiver stalls, the output register holds, the stepper halts, and input
//   is taken until the queue is full.
//   Reset empties queue and output, drops any line, restores 1024 x 768,
//   pitch 1024, surface present.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clipped_line_rasterizer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [clr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [clr_pkg::DIM_BITS-1:0]        cfg_wdata,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// x_start, y_start, x_end, y_end, line_color
	input  wire logic [clr_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// opcode
	input  wire logic                                s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// pixel_x, pixel_y, word_index, pixel_color
	output logic [clr_pkg::OUT_DATA_BITS-1:0]        m_tdata,
	// visible
	output logic                                     m_tuser,
	output logic                                     m_tlast
);

	clr_pkg::cfg_t cfg_q;
	clr_pkg::cmd_t q_cmd, head_cmd;
	clr_pkg::pix_t px_s1;
	logic          q_push, q_full, head_valid, pop, px_ready, px_valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width   <= clr_pkg::WIDTH_RST;
			cfg_q.height  <= clr_pkg::HEIGHT_RST;
			cfg_q.pitch   <= clr_pkg::PITCH_RST;
			cfg_q.surface <= 1'b1;
		end else if (cfg_we) begin
			unique case (clr_pkg::reg_idx_t'(cfg_index))
				clr_pkg::REG_WIDTH:   cfg_q.width   <= cfg_wdata;
				clr_pkg::REG_HEIGHT:  cfg_q.height  <= cfg_wdata;
				clr_pkg::REG_PITCH:   cfg_q.pitch   <= cfg_wdata;
				clr_pkg::REG_SURFACE: cfg_q.surface <= cfg_wdata[0];
			endcase
		end
	end

	clr_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	clr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_cmd     (q_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	clr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.px_ready    (px_ready),
		.px_valid_s1 (px_valid_s1),
		.px_s1       (px_s1)
	);

	clr_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.px_valid_s1 (px_valid_s1),
		.px_s1       (px_s1),
		.px_ready    (px_ready),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

`default_nettype wire

/* src/clr_checker.sv */
// ----------------------------------------------------------------------------
// clr_checker
// Port-level assertions for the clipped line rasterizer, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "clipped_line_rasterizer_defines.svh"

module clr_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [clr_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input wire logic                                m_tuser,
	input wire logic                                m_tlast
);

	localparam int C = clr_pkg::COORD_BITS;

	logic [clr_pkg::INDEX_BITS-1:0] out_index;

	assign out_index = m_tdata[2*C +: clr_pkg::INDEX_BITS];

	`CLR_ASSERT_ALWAYS(a_reset_no_beat, clk, !arst_n, !m_tvalid, "output beat during reset")

	`CLR_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"stalled output beat changed")

	`CLR_ASSERT_IMPLY(a_hidden_index, clk, arst_n, m_tvalid && !m_tuser,
		out_index == '0, "invisible pixel with nonzero index")

	`CLR_ASSERT_IMPLY(a_visible_coords, clk, arst_n, m_tvalid && m_tuser,
		!m_tdata[C-1] && !m_tdata[2*C-1], "visible pixel with negative coordinate")

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (.*);

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clipped line rasterizer. Directed lines cover
// the coordinate extremes, single-pixel lines, reloads mid-line and steps
// while idle. Random short lines follow under several screen settings, with
// random idle bursts on both sides and one long output stall. Each pixel beat
// is checked field by field against a Bresenham predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic [clr_pkg::COORD_BITS-1:0] x;
		logic [clr_pkg::COORD_BITS-1:0] y;
		logic [clr_pkg::INDEX_BITS-1:0] index;
		logic                           vis;
		logic [clr_pkg::COLOR_BITS-1:0] color;
		logic                           last;
	} pixel_t;

	class pixel_predictor;
		int unsigned width = 1024;
		int unsigned height = 768;
		int unsigned pitch = 1024;
		bit          surface = 1;
		longint cur_x, cur_y, end_x, end_y, delta_x, neg_delta_y, err_term;
		bit     x_neg, y_neg, active;
		logic [clr_pkg::COLOR_BITS-1:0] color;
		pixel_t expected_pixels[$];
		int     errors;

		function void set_reg(clr_pkg::reg_idx_t idx, logic [clr_pkg::DIM_BITS-1:0] value);
			case (idx)
				clr_pkg::REG_WIDTH:   width = value;
				clr_pkg::REG_HEIGHT:  height = value;
				clr_pkg::REG_PITCH:   pitch = value;
				clr_pkg::REG_SURFACE: surface = value[0];
			endcase
		endfunction

		function void take_command(clr_pkg::cmd_kind_t kind,
			logic [clr_pkg::IN_DATA_BITS-1:0] d);
			longint e2;
			pixel_t p;
			if (kind == clr_pkg::CMD_LOAD) begin
				cur_x = longint'($signed(d[15:0]));
				cur_y = longint'($signed(d[31:16]));
				end_x = longint'($signed(d[47:32]));
				end_y = longint'($signed(d[63:48]));
				delta_x = (end_x > cur_x) ? end_x - cur_x : cur_x - end_x;
				neg_delta_y = (end_y > cur_y) ? cur_y - end_y : end_y - cur_y;
				x_neg = !(cur_x < end_x);
				y_neg = !(cur_y < end_y);
				err_term = delta_x + neg_delta_y;
				color = d[95:64];
				active = 1;
				return;
			end
			if (!active)
				return;
			p.x = cur_x[15:0];
			p.y = cur_y[15:0];
			p.vis = surface && cur_x >= 0 && cur_x < width && cur_y >= 0 && cur_y < height;
			p.index = p.vis ? clr_pkg::INDEX_BITS'(cur_y * pitch + cur_x) : '0;
			p.color = color;
			p.last = (cur_x == end_x) && (cur_y == end_y);
			expected_pixels.push_back(p);
			if (p.last) begin
				active = 0;
			end else begin
				e2 = 2 * err_term;
				if (e2 >= neg_delta_y) begin
					err_term += neg_delta_y;
					cur_x += x_neg ? -1 : 1;
				end
				if (e2 <= delta_x) begin
					err_term += delta_x;
					cur_y += y_neg ? -1 : 1;
				end
			end
		endfunction

		function void check_pixel(logic [clr_pkg::OUT_DATA_BITS-1:0] d, logic vis,
			logic last);
			pixel_t p;
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel beat: x=%0d y=%0d", $signed(d[15:0]),
					$signed(d[31:16]));
				errors++;
				return;
			end
			p = expected_pixels.pop_front();
			if (d[15:0] !== p.x) begin
				$error("pixel_x: expected %0d, got %0d", $signed(p.x), $signed(d[15:0]));
				errors++;
			end
			if (d[31:16] !== p.y) begin
				$error("pixel_y: expected %0d, got %0d", $signed(p.y), $signed(d[31:16]));
				errors++;
			end
			if (d[59:32] !== p.index) begin
				$error("word_index: expected %0h, got %0h", p.index, d[59:32]);
				errors++;
			end
			if (vis !== p.vis) begin
				$error("visible: expected %0b, got %0b", p.vis, vis);
				errors++;
			end
			if (d[91:60] !== p.color) begin
				$error("pixel_color: expected %0h, got %0h", p.color, d[91:60]);
				errors++;
			end
			if (last !== p.last) begin
				$error("last: expected %0b, got %0b", p.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	clr_pkg::reg_idx_t                 cfg_index;
	logic [clr_pkg::DIM_BITS-1:0]      cfg_wdata;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [clr_pkg::IN_DATA_BITS-1:0]  s_tdata;
	logic                              s_tuser;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [clr_pkg::OUT_DATA_BITS-1:0] m_tdata;
	logic                              m_tuser;
	logic                              m_tlast;

	pixel_predictor book = new();
	bit no_idle;
	bit long_stall;
	int items;
	int scr_w = 1024;
	int scr_h = 768;

	clipped_line_rasterizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#4ms;
		$display("FAILURE");
		$finish;
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_stall) begin
				m_tready = 1'b0;
				repeat (300) @(negedge clk);
				long_stall = 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_pixel(m_tdata, m_tuser, m_tlast);
	end

	task automatic send_beat(clr_pkg::cmd_kind_t kind, logic [clr_pkg::IN_DATA_BITS-1:0] d);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = d;
		do @(posedge clk); while (!s_tready);
		book.take_command(kind, d);
		items++;
	endtask

	task automatic load_line(int x0, int y0, int x1, int y1, logic [31:0] color);
		send_beat(clr_pkg::CMD_LOAD, {color, 16'(y1), 16'(x1), 16'(y0), 16'(x0)});
	endtask

	task automatic step_n(int n);
		repeat (n) send_beat(clr_pkg::CMD_STEP, {$urandom, $urandom, $urandom});
	endtask

	task automatic stop_input();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(clr_pkg::reg_idx_t idx, int value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = clr_pkg::DIM_BITS'(value);
		book.set_reg(idx, clr_pkg::DIM_BITS'(value));
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_screen(int w, int h, int p, int surf);
		stop_input();
		while (book.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		write_reg(clr_pkg::REG_WIDTH, w);
		write_reg(clr_pkg::REG_HEIGHT, h);
		write_reg(clr_pkg::REG_PITCH, p);
		write_reg(clr_pkg::REG_SURFACE, surf);
		scr_w = w;
		scr_h = h;
	endtask

	function automatic int pick_coord(int lim);
		int v;
		case ($urandom_range(0, 2))
			0:       v = int'($urandom_range(0, 65535)) - 32768;
			1:       v = int'($urandom_range(0, 7)) - 4;
			default: v = lim + int'($urandom_range(0, 7)) - 4;
		endcase
		if (v > 32720)
			v = 32720;
		if (v < -32720)
			v = -32720;
		return v;
	endfunction

	task automatic random_line();
		int x0, y0, x1, y1, span, ax, ay, n;
		x0 = pick_coord(scr_w);
		y0 = pick_coord(scr_h);
		span = ($urandom_range(0, 9) == 0) ? 40 : 8;
		x1 = x0 + int'($urandom_range(0, 2 * span)) - span;
		y1 = y0 + int'($urandom_range(0, 2 * span)) - span;
		ax = (x1 > x0) ? x1 - x0 : x0 - x1;
		ay = (y1 > y0) ? y1 - y0 : y0 - y1;
		n = ((ax > ay) ? ax : ay) + 1;
		case ($urandom_range(0, 9))
			0: n = $urandom_range(0, n - 1);   // cut short by the next load
			1: n += $urandom_range(1, 2);      // trailing steps while idle
			default: ;
		endcase
		load_line(x0, y0, x1, y1, $urandom);
		step_n(n);
	endtask

	initial begin
		int ph_w[8] = '{1024, 1, 32767, 16384, 0, 64, 0, 640};
		int ph_h[8] = '{768, 1, 32767, 16384, 0, 48, 0, 480};
		int ph_p[8] = '{1024, 1, 32767, 16384, 7, 100, 0, 640};
		int ph_s[8] = '{1, 1, 1, 1, 1, 0, 1, 1};
		int stop_at;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = clr_pkg::REG_WIDTH;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = clr_pkg::CMD_STEP;
		no_idle = 1'b0;
		long_stall = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines under the reset screen
		step_n(1);
		load_line(0, 0, 0, 0, 32'hFFFF_FFFF);
		step_n(2);
		load_line(-32768, 32767, 32767, -32768, 32'h0);
		step_n(3);
		load_line(32767, -32768, -32768, 32767, 32'hA5A5_5A5A);
		step_n(1);
		load_line(1022, 766, 1025, 769, 32'h1234_5678);
		step_n(4);
		load_line(-2, -1, 1, 2, 32'h8000_0001);
		step_n(4);
		load_line(5, 0, 6, 4, 32'h0F0F_F0F0);
		step_n(5);
		load_line(3, 3, 0, 1, 32'hDEAD_BEEF);
		step_n(4);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 6)
				set_screen($urandom_range(1, 2000), $urandom_range(1, 2000),
					$urandom_range(1, 32767), 1);
			else
				set_screen(ph_w[ph], ph_h[ph], ph_p[ph], ph_s[ph]);
			if (ph == 7)
				no_idle = 1'b1;
			if (ph == 1) begin
				long_stall = 1'b1;
				load_line(-20, -20, 20, 5, $urandom);
				step_n(41);
			end
			stop_at = items + 75;
			while (items < stop_at) begin
				if ($urandom_range(0, 11) == 0)
					send_beat(clr_pkg::cmd_kind_t'($urandom_range(0, 1)),
						{$urandom, $urandom, $urandom});
				else
					random_line();
			end
		end

		stop_input();
		while (book.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (book.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/clr_pkg.sv
src/clr_front.sv
src/clr_queue.sv
src/clr_back.sv
src/clr_out.sv
src/clipped_line_rasterizer.sv
src/clr_checker.sv
verif/testbench.sv
